>>> rtl/core/bsf_pkg.sv
// Shared constants for the backlight smoothstep fader.
`timescale 1ns / 1ps
package bsf_pkg;
	localparam int DUR_W = 12;
	localparam int T_W   = 10;
	localparam int LVL_W = 8;
	localparam int TIME_W = 32;

	localparam logic [1:0] KIND_REQ = 2'd1;
	localparam logic [1:0] KIND_REL = 2'd2;

	localparam logic [1:0] TACT_NONE   = 2'd0;
	localparam logic [1:0] TACT_STOP   = 2'd1;
	localparam logic [1:0] TACT_RE40   = 2'd2;
	localparam logic [1:0] TACT_RE1000 = 2'd3;

	localparam logic [LVL_W-1:0] SLEEP_LVL = 8'd2;
	localparam logic [11:0] CURVE_K = 12'd3072;
	localparam logic [18:0] ROUND_HALF = 19'd512;
endpackage

>>> rtl/core/bsf_div.sv
// Restoring divider, one quotient bit per cycle: (num << T_W) / den, num < den.
`timescale 1ns / 1ps
module bsf_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [bsf_pkg::DUR_W-1:0] num,
	input  logic [bsf_pkg::DUR_W-1:0] den,
	output logic                     done,
	output logic [bsf_pkg::T_W-1:0]   quo
);
	import bsf_pkg::*;
	localparam int CW = $clog2(T_W + 1);

	logic [DUR_W-1:0] rem_q, den_q;
	logic [T_W-1:0]   quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [DUR_W:0]   r2;
	logic             ge;

	assign r2 = {rem_q, 1'b0};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(T_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DUR_W'(r2 - {1'b0, den_q}) : r2[DUR_W-1:0];
			quo_q <= {quo_q[T_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

>>> rtl/core/bsf_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module bsf_mul #(
	parameter int AW = 20,
	parameter int BW = 12,
	parameter int PW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [PW-1:0] p
);
	localparam int CW = $clog2(BW + 1);

	logic [PW-1:0] a_q, acc_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[PW-2:0], 1'b0};
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

>>> rtl/core/backlight_smoothstep_fader.sv
// Top level of the backlight smoothstep fader.
//  channel | dir | fields
//  s_*     | in  | tuser: kind; tdata: request, time, flags, epochs, stock level
//  m_*     | out | tdata: apply_valid, apply_level, hold_frame, clear_frame, timer_action
// One beat in, one beat out; a fade step runs accept, update, elapsed check,
// divide, three multiplies and output, while other beats skip the divide
// and multiplies. Cycles with m_tready low lengthen either kind of beat.
// The shared shift-add multiplier takes most of a fade step's time.
// Reset clears fader state, not the captured beat or t_q; no new beat is taken until the result is taken.
`timescale 1ns / 1ps
module backlight_smoothstep_fader #(
	parameter int EPOCH_BITS  = 10,
	parameter int REASSERT_MS = 1000
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [1:0] s_tuser, // kind
	// desired_level, visible, duration_ms, request_epoch, now_ms, lease_active,
	// display_on, frame_pending, frame_epoch, stock_level
	input  logic [((63 + 2*EPOCH_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// apply_valid, apply_level, hold_frame, clear_frame, timer_action
	output logic [15:0] m_tdata
);
	import bsf_pkg::*;
	localparam int E = EPOCH_BITS;
	localparam int O_REP  = 20;
	localparam int O_NOW  = O_REP + E;
	localparam int O_LEA  = O_NOW + 32;
	localparam int O_PEP  = O_LEA + 3;
	localparam int O_STK  = O_PEP + E;

	typedef enum logic [2:0] {S_IDLE, S_UPD, S_ELAP, S_DIV, S_M1, S_M2, S_M3, S_OUT}
		state_t;
	state_t st_q;

	logic [1:0] kind_q;
	logic [6:0] des_q;
	logic vis_q, lease_q, disp_q, pend_q;
	logic [DUR_W-1:0] dur_q;
	logic [E-1:0] rep_q, pep_q, wep_q;
	logic [TIME_W-1:0] now_q, fstart_q, lat_q;
	logic [LVL_W-1:0] stock_q;

	logic active_q, ww_q, shown_q;
	logic [LVL_W-1:0] lastdes_q, from_q, target_q, cur_q;
	logic [DUR_W-1:0] fdur_q;
	logic [T_W-1:0] t_q;

	logic [12:0] out_q;

	// request and wake update
	logic rel, req, act_i, shown_i, change, ww_n, wake_go;
	logic [LVL_W-1:0] from_i, cur_i, from_n, target_n;
	assign rel     = (kind_q == KIND_REL) || !lease_q;
	assign req     = kind_q == KIND_REQ;
	assign act_i   = active_q || req;
	assign shown_i = active_q ? shown_q : 1'b0;
	assign cur_i   = active_q ? cur_q : SLEEP_LVL;
	assign from_i  = active_q ? from_q : SLEEP_LVL;
	assign change  = req && ((vis_q != shown_i) || (vis_q && {1'b0, des_q} != lastdes_q));
	assign from_n  = change ? cur_i : from_i;
	assign target_n = change ? (vis_q ? {1'b0, des_q} : SLEEP_LVL)
		: (active_q ? target_q : SLEEP_LVL);
	always_comb begin
		ww_n = ww_q;
		if (change && vis_q && !shown_i) ww_n = 1'b1;
		if (req && !vis_q) ww_n = 1'b0;
	end
	assign wake_go = ww_n && pend_q &&
		(pep_q != ((change && vis_q && !shown_i) ? rep_q : wep_q));

	// timing
	logic [TIME_W-1:0] elapsed;
	logic short_fade, up;
	logic [LVL_W-1:0] diff;
	assign elapsed    = now_q - fstart_q;
	assign short_fade = (fdur_q == '0) || (elapsed >= TIME_W'(fdur_q));
	assign up         = target_q >= from_q;
	assign diff       = up ? target_q - from_q : from_q - target_q;

	logic div_start, div_done;
	logic [T_W-1:0] quo;
	bsf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(elapsed[DUR_W-1:0]), .den(fdur_q), .done(div_done), .quo(quo)
	);

	logic mul_start, mul_done;
	logic [19:0] mul_a;
	logic [11:0] mul_b;
	logic [31:0] mul_p;
	bsf_mul #(.AW(20), .BW(12), .PW(32)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	logic [18:0] rsum;
	logic [LVL_W-1:0] q8, lvl_f;
	assign rsum = mul_p[18:0] + ROUND_HALF;
	assign q8   = rsum[17:10];
	assign lvl_f = up ? from_q + q8 : from_q - q8;

	always_comb begin
		div_start = 1'b0;
		mul_start = 1'b0;
		mul_a = {10'd0, t_q};
		mul_b = {2'd0, t_q};
		case (st_q)
			S_ELAP: div_start = !ww_q && !short_fade && active_q;
			S_DIV: begin
				mul_start = div_done;
				mul_a = {10'd0, quo};
				mul_b = {2'd0, quo};
			end
			S_M1: begin
				mul_start = mul_done;
				mul_a = mul_p[19:0];
				mul_b = CURVE_K - {1'b0, t_q, 1'b0};
			end
			S_M2: begin
				mul_start = mul_done;
				mul_a = {10'd0, mul_p[29:20]};
				mul_b = {4'd0, diff};
			end
			default: ;
		endcase
	end

	// finish: apply decision
	logic fin, fin_lvl_ok, app;
	logic [LVL_W-1:0] lvl;
	assign fin = (st_q == S_ELAP && (ww_q || short_fade || !active_q))
		|| (st_q == S_M3 && mul_done);
	assign lvl = (st_q == S_M3) ? lvl_f : (ww_q ? cur_q : target_q);
	assign fin_lvl_ok = lvl != cur_q;
	assign app = disp_q && (fin_lvl_ok || lat_q == '0 ||
		(now_q - lat_q) >= TIME_W'(REASSERT_MS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			active_q <= 1'b0; ww_q <= 1'b0; shown_q <= 1'b0;
			lastdes_q <= '0; from_q <= '0; target_q <= '0; cur_q <= '0;
			fdur_q <= '0; fstart_q <= '0; lat_q <= '0; wep_q <= '0;
			out_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (s_tvalid) st_q <= S_UPD;
				S_UPD: begin
					if (rel) begin
						out_q <= {TACT_STOP, 1'b0, 1'b0,
							(active_q && disp_q) ? stock_q : 8'd0, active_q && disp_q};
						active_q <= 1'b0;
						ww_q <= 1'b0;
						st_q <= S_OUT;
					end else begin
						active_q <= act_i;
						if (req) begin
							shown_q <= vis_q;
							lastdes_q <= {1'b0, des_q};
							if (!active_q) begin
								cur_q <= SLEEP_LVL;
								lat_q <= '0;
							end
						end
						from_q <= from_n;
						target_q <= target_n;
						if (change) fdur_q <= dur_q;
						if (change && vis_q && !shown_i) wep_q <= rep_q;
						ww_q <= act_i ? (ww_n && !wake_go) : ww_n;
						if ((act_i && wake_go) || change) fstart_q <= now_q;
						st_q <= S_ELAP;
					end
				end
				S_ELAP: begin
					if (!active_q) begin
						out_q <= '0;
						st_q <= S_OUT;
					end else if (fin) st_q <= S_OUT;
					else st_q <= S_DIV;
				end
				S_DIV: if (div_done) st_q <= S_M1;
				S_M1: if (mul_done) st_q <= S_M2;
				S_M2: if (mul_done) st_q <= S_M3;
				S_M3: if (mul_done) st_q <= S_OUT;
				S_OUT: if (m_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
			if (fin && active_q) begin
				cur_q <= lvl;
				if (app) lat_q <= (now_q == '0) ? TIME_W'(1) : now_q;
				out_q <= {(!ww_q && lvl != target_q) ? TACT_RE40 : TACT_RE1000,
					!ww_q && !shown_q && lvl == SLEEP_LVL,
					ww_q || !shown_q,
					app ? lvl : 8'd0, app};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_DIV && div_done) t_q <= quo;
		if (s_tvalid && s_tready) begin
			kind_q  <= s_tuser;
			des_q   <= s_tdata[6:0];
			vis_q   <= s_tdata[7];
			dur_q   <= s_tdata[19:8];
			rep_q   <= s_tdata[O_REP +: E];
			now_q   <= s_tdata[O_NOW +: 32];
			lease_q <= s_tdata[O_LEA];
			disp_q  <= s_tdata[O_LEA + 1];
			pend_q  <= s_tdata[O_LEA + 2];
			pep_q   <= s_tdata[O_PEP +: E];
			stock_q <= s_tdata[O_STK +: 8];
		end
	end

	assign s_tready = st_q == S_IDLE;
	assign m_tvalid = st_q == S_OUT;
	assign m_tdata  = {3'd0, out_q};

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output both open");
	a_stop_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12:11] == TACT_STOP |-> !m_tdata[9] && !m_tdata[10])
		else $error("stop with frame hold");
	a_apply_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
		else $error("level without apply");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready) else $error("no return to idle");
`endif
endmodule
